// ===== design/rrc_pkg.sv =====
// Shared types and constants of the RGB/RYB color converter.
// No dependencies; every other design file refers to it by scoped names.

package rrc_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int QUOT_BITS    = FRAC_BITS + 2;
   localparam int FRONT_STAGES = 4;
   localparam int BACK_STAGES  = 2;
   localparam int PIPE_LATENCY = FRONT_STAGES + QUOT_BITS + BACK_STAGES;

   typedef enum logic {
      DIR_TO_RYB = 1'b0,
      DIR_TO_RGB = 1'b1
   } dir_type;

   typedef struct packed {
      logic    valid;
      dir_type dir;
   } ctl_type;

endpackage

// ===== design/rgb_ryb_color_converter.sv =====
// Top level of the RGB/RYB color converter.
// Instantiates rrc_front, rrc_divider and rrc_back; uses rrc_pkg.

// The converter takes one color transaction in every clock cycle while not busy and
// returns each result in order, after min/max and chroma remap, the divider that forms
// the scale ratio one quotient bit per stage, and the multiply and the saturating add.
// The result is on the rsp ports for one cycle with rsp_valid high and the receiver
// cannot hold it off. The block is busy only while reset is high; items in flight at
// a reset are dropped.

module rgb_ryb_color_converter #(
   parameter int CHANNEL_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_type,
   input  logic [CHANNEL_BITS-1:0] req_first,
   input  logic [CHANNEL_BITS-1:0] req_second,
   input  logic [CHANNEL_BITS-1:0] req_third,
   output logic                    rsp_valid,
   output logic [CHANNEL_BITS-1:0] rsp_first,
   output logic [CHANNEL_BITS-1:0] rsp_second,
   output logic [CHANNEL_BITS-1:0] rsp_third
);

   localparam int CB        = CHANNEL_BITS;
   localparam int XB        = CHANNEL_BITS + 1;
   localparam int NB        = CHANNEL_BITS + rrc_pkg::FRAC_BITS + 1;
   localparam int SIDE_BITS = 3 * XB + CB;

   rrc_pkg::ctl_type              req_ctl;
   rrc_pkg::ctl_type              front_ctl;
   rrc_pkg::ctl_type              div_ctl;
   logic [XB-1:0]                 front_x0, front_x1, front_x2;
   logic [CB-1:0]                 front_achro;
   logic [NB-1:0]                 front_num;
   logic [XB-1:0]                 front_den;
   logic [SIDE_BITS-1:0]          div_side;
   logic [rrc_pkg::QUOT_BITS-1:0] div_quo;

   assign busy = reset;

   always_comb begin
      req_ctl.valid = start && !busy;
      req_ctl.dir   = rrc_pkg::dir_type'(req_type);
   end

   rrc_front #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (req_ctl),
      .in_a     (req_first),
      .in_b     (req_second),
      .in_c     (req_third),
      .out_ctl  (front_ctl),
      .out_x0   (front_x0),
      .out_x1   (front_x1),
      .out_x2   (front_x2),
      .out_achro(front_achro),
      .out_num  (front_num),
      .out_den  (front_den)
   );

   rrc_divider #(
      .CHANNEL_BITS(CHANNEL_BITS),
      .SIDE_BITS   (SIDE_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (front_ctl),
      .in_num  (front_num),
      .in_den  (front_den),
      .in_side ({front_achro, front_x2, front_x1, front_x0}),
      .out_ctl (div_ctl),
      .out_quo (div_quo),
      .out_side(div_side)
   );

   rrc_back #(
      .CHANNEL_BITS(CHANNEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (div_ctl),
      .in_quo    (div_quo),
      .in_x0     (div_side[XB-1:0]),
      .in_x1     (div_side[2*XB-1:XB]),
      .in_x2     (div_side[3*XB-1:2*XB]),
      .in_achro  (div_side[SIDE_BITS-1:3*XB]),
      .out_valid (rsp_valid),
      .out_first (rsp_first),
      .out_second(rsp_second),
      .out_third (rsp_third)
   );

endmodule

// ===== design/rrc_front.sv =====
// Front pipeline of the color converter: achromatic split, chroma remap,
// divisor maximum and dividend. Four register stages. Uses rrc_pkg.

module rrc_front #(
   parameter int CHANNEL_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rrc_pkg::ctl_type                      in_ctl,
   input  logic [CHANNEL_BITS-1:0]               in_a,
   input  logic [CHANNEL_BITS-1:0]               in_b,
   input  logic [CHANNEL_BITS-1:0]               in_c,
   output rrc_pkg::ctl_type                      out_ctl,
   output logic [CHANNEL_BITS:0]                 out_x0,
   output logic [CHANNEL_BITS:0]                 out_x1,
   output logic [CHANNEL_BITS:0]                 out_x2,
   output logic [CHANNEL_BITS-1:0]               out_achro,
   output logic [CHANNEL_BITS+rrc_pkg::FRAC_BITS:0] out_num,
   output logic [CHANNEL_BITS:0]                 out_den
);

   localparam int CB = CHANNEL_BITS;
   localparam int XB = CHANNEL_BITS + 1;
   localparam int NB = CHANNEL_BITS + rrc_pkg::FRAC_BITS + 1;

   // Stage A: smallest and largest channel.
   logic [CB-1:0]    mn_ab;
   logic [CB-1:0]    mx_ab;
   logic [CB-1:0]    mn_in;
   logic [CB-1:0]    mx_in;
   rrc_pkg::ctl_type a_ctl_ff;
   logic [CB-1:0]    a_c0_ff, a_c1_ff, a_c2_ff, a_mn_ff, a_mx_ff;

   always_comb begin
      mn_ab = (in_a < in_b) ? in_a : in_b;
      mx_ab = (in_a > in_b) ? in_a : in_b;
      mn_in = (mn_ab < in_c) ? mn_ab : in_c;
      mx_in = (mx_ab > in_c) ? mx_ab : in_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      a_c0_ff <= in_a;
      a_c1_ff <= in_b;
      a_c2_ff <= in_c;
      a_mn_ff <= mn_in;
      a_mx_ff <= mx_in;
   end

   // Stage B: chroma components, chroma maximum and complementary part.
   rrc_pkg::ctl_type b_ctl_ff;
   logic [CB-1:0]    b_c0_ff, b_c1_ff, b_c2_ff, b_m_ff, b_achro_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
      end else begin
         b_ctl_ff <= a_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_c0_ff    <= a_c0_ff - a_mn_ff;
      b_c1_ff    <= a_c1_ff - a_mn_ff;
      b_c2_ff    <= a_c2_ff - a_mn_ff;
      b_m_ff     <= a_mx_ff - a_mn_ff;
      b_achro_ff <= ~a_mx_ff;
   end

   // Stage C: remap the chroma into the target model, kept with one extra bit.
   logic [CB-1:0]    pair_min;
   logic [XB-1:0]    x0_in, x1_in, x2_in;
   rrc_pkg::ctl_type c_ctl_ff;
   logic [XB-1:0]    c_x0_ff, c_x1_ff, c_x2_ff;
   logic [CB-1:0]    c_m_ff, c_achro_ff;

   always_comb begin
      if (b_ctl_ff.dir == rrc_pkg::DIR_TO_RYB) begin
         pair_min = (b_c0_ff < b_c1_ff) ? b_c0_ff : b_c1_ff;
         x0_in    = {b_c0_ff - pair_min, 1'b0};
         x2_in    = {1'b0, b_c2_ff} + {1'b0, b_c1_ff} - {1'b0, pair_min};
      end else begin
         pair_min = (b_c1_ff < b_c2_ff) ? b_c1_ff : b_c2_ff;
         x0_in    = {1'b0, b_c0_ff} + {1'b0, b_c1_ff} - {1'b0, pair_min};
         x2_in    = {b_c2_ff - pair_min, 1'b0};
      end
      x1_in = {1'b0, b_c1_ff} + {1'b0, pair_min};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff <= '0;
      end else begin
         c_ctl_ff <= b_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_x0_ff    <= x0_in;
      c_x1_ff    <= x1_in;
      c_x2_ff    <= x2_in;
      c_m_ff     <= b_m_ff;
      c_achro_ff <= b_achro_ff;
   end

   // Stage D: divisor is the largest target chroma, dividend the source chroma maximum.
   logic [XB-1:0]    mx01;
   logic [XB-1:0]    den_in;
   logic [NB-1:0]    num_in;
   rrc_pkg::ctl_type d_ctl_ff;
   logic [XB-1:0]    d_x0_ff, d_x1_ff, d_x2_ff, d_den_ff;
   logic [CB-1:0]    d_achro_ff;
   logic [NB-1:0]    d_num_ff;

   always_comb begin
      mx01   = (c_x0_ff > c_x1_ff) ? c_x0_ff : c_x1_ff;
      den_in = (mx01 > c_x2_ff) ? mx01 : c_x2_ff;
      if (c_ctl_ff.dir == rrc_pkg::DIR_TO_RYB) begin
         num_in = {c_m_ff, {(rrc_pkg::FRAC_BITS + 1){1'b0}}};
      end else begin
         num_in = {1'b0, c_m_ff, {rrc_pkg::FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctl_ff <= '0;
      end else begin
         d_ctl_ff <= c_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_x0_ff    <= c_x0_ff;
      d_x1_ff    <= c_x1_ff;
      d_x2_ff    <= c_x2_ff;
      d_achro_ff <= c_achro_ff;
      d_num_ff   <= num_in;
      d_den_ff   <= den_in;
   end

   assign out_ctl   = d_ctl_ff;
   assign out_x0    = d_x0_ff;
   assign out_x1    = d_x1_ff;
   assign out_x2    = d_x2_ff;
   assign out_achro = d_achro_ff;
   assign out_num   = d_num_ff;
   assign out_den   = d_den_ff;

endmodule

// ===== design/rrc_divider.sv =====
// Pipelined restoring divider of the color converter, one quotient bit per stage.
// Carries an opaque side vector alongside. Uses rrc_pkg.

module rrc_divider #(
   parameter int CHANNEL_BITS = 16,
   parameter int SIDE_BITS    = 1
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  rrc_pkg::ctl_type                         in_ctl,
   input  logic [CHANNEL_BITS+rrc_pkg::FRAC_BITS:0] in_num,
   input  logic [CHANNEL_BITS:0]                    in_den,
   input  logic [SIDE_BITS-1:0]                     in_side,
   output rrc_pkg::ctl_type                         out_ctl,
   output logic [rrc_pkg::QUOT_BITS-1:0]            out_quo,
   output logic [SIDE_BITS-1:0]                     out_side
);

   localparam int XB = CHANNEL_BITS + 1;
   localparam int NB = CHANNEL_BITS + rrc_pkg::FRAC_BITS + 1;
   localparam int QB = rrc_pkg::QUOT_BITS;

   rrc_pkg::ctl_type     ctl_tap  [0:QB];
   logic [XB-1:0]        rem_tap  [0:QB];
   logic [NB-1:0]        num_tap  [0:QB];
   logic [XB-1:0]        den_tap  [0:QB];
   logic [QB-1:0]        quo_tap  [0:QB];
   logic [SIDE_BITS-1:0] side_tap [0:QB];

   rrc_pkg::ctl_type     ctl_ff  [0:QB-1];
   logic [XB-1:0]        rem_ff  [0:QB-1];
   logic [NB-1:0]        num_ff  [0:QB-1];
   logic [XB-1:0]        den_ff  [0:QB-1];
   logic [QB-1:0]        quo_ff  [0:QB-1];
   logic [SIDE_BITS-1:0] side_ff [0:QB-1];

   // The upper dividend bits are below the divisor whenever the color has chroma, so they seed the remainder.
   assign ctl_tap[0]  = in_ctl;
   assign rem_tap[0]  = {2'b00, in_num[NB-1:QB]};
   assign num_tap[0]  = in_num;
   assign den_tap[0]  = in_den;
   assign quo_tap[0]  = '0;
   assign side_tap[0] = in_side;

   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int BitIdx = QB - 1 - s;
      logic [XB:0]   trial;
      logic [XB:0]   diff;
      logic          take;
      logic [XB-1:0] rem_in;
      logic [QB-1:0] quo_in;

      always_comb begin
         trial  = {rem_tap[s], num_tap[s][BitIdx]};
         diff   = trial - {1'b0, den_tap[s]};
         take   = (trial >= {1'b0, den_tap[s]});
         rem_in = take ? diff[XB-1:0] : trial[XB-1:0];
         quo_in = {quo_tap[s][QB-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else begin
            ctl_ff[s] <= ctl_tap[s];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         num_ff[s]  <= num_tap[s];
         den_ff[s]  <= den_tap[s];
         quo_ff[s]  <= quo_in;
         side_ff[s] <= side_tap[s];
      end

      assign ctl_tap[s+1]  = ctl_ff[s];
      assign rem_tap[s+1]  = rem_ff[s];
      assign num_tap[s+1]  = num_ff[s];
      assign den_tap[s+1]  = den_ff[s];
      assign quo_tap[s+1]  = quo_ff[s];
      assign side_tap[s+1] = side_ff[s];
   end

   assign out_ctl  = ctl_tap[QB];
   assign out_quo  = quo_tap[QB];
   assign out_side = side_tap[QB];

endmodule

// ===== design/rrc_back.sv =====
// Back pipeline of the color converter: rescale by the ratio, add the
// achromatic part and saturate. Two register stages. Uses rrc_pkg.

module rrc_back #(
   parameter int CHANNEL_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rrc_pkg::ctl_type              in_ctl,
   input  logic [rrc_pkg::QUOT_BITS-1:0] in_quo,
   input  logic [CHANNEL_BITS:0]         in_x0,
   input  logic [CHANNEL_BITS:0]         in_x1,
   input  logic [CHANNEL_BITS:0]         in_x2,
   input  logic [CHANNEL_BITS-1:0]       in_achro,
   output logic                          out_valid,
   output logic [CHANNEL_BITS-1:0]       out_first,
   output logic [CHANNEL_BITS-1:0]       out_second,
   output logic [CHANNEL_BITS-1:0]       out_third
);

   localparam int CB = CHANNEL_BITS;
   localparam int XB = CHANNEL_BITS + 1;
   localparam int PB = XB + rrc_pkg::QUOT_BITS;
   localparam int SB = PB - rrc_pkg::FRAC_BITS;

   logic [XB-1:0]    xs [0:2];
   rrc_pkg::ctl_type m_ctl_ff;
   logic [PB-1:0]    prod_ff [0:2];
   logic [CB-1:0]    m_achro_ff;
   logic [CB-1:0]    res_in [0:2];
   logic             valid_ff;
   logic [CB-1:0]    res_ff [0:2];

   assign xs[0] = in_x0;
   assign xs[1] = in_x1;
   assign xs[2] = in_x2;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ctl_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         m_ctl_ff <= in_ctl;
         valid_ff <= m_ctl_ff.valid;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [SB-1:0] scaled;
      logic [SB:0]   sum;

      always_comb begin
         if (m_ctl_ff.dir == rrc_pkg::DIR_TO_RYB) begin
            scaled = SB'(prod_ff[k] >> (rrc_pkg::FRAC_BITS + 1));
         end else begin
            scaled = prod_ff[k][PB-1:rrc_pkg::FRAC_BITS];
         end
         sum = {1'b0, scaled} + (SB + 1)'(m_achro_ff);
         res_in[k] = (sum > (SB + 1)'({CB{1'b1}})) ? {CB{1'b1}} : sum[CB-1:0];
      end

      always_ff @(posedge clock) begin
         prod_ff[k] <= PB'(xs[k]) * PB'(in_quo);
         res_ff[k]  <= res_in[k];
      end
   end

   always_ff @(posedge clock) begin
      m_achro_ff <= in_achro;
   end

   assign out_valid  = valid_ff;
   assign out_first  = res_ff[0];
   assign out_second = res_ff[1];
   assign out_third  = res_ff[2];

endmodule

// ===== design/rrc_checker.sv =====
// Port-level checks of the RGB/RYB color converter and the bind that attaches them.
// Depends on rrc_pkg and on the top level rgb_ryb_color_converter.

module rrc_checker #(
   parameter int CHANNEL_BITS = 16
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic [CHANNEL_BITS-1:0] req_first,
   input logic [CHANNEL_BITS-1:0] req_second,
   input logic [CHANNEL_BITS-1:0] req_third,
   input logic                    rsp_valid,
   input logic [CHANNEL_BITS-1:0] rsp_first,
   input logic [CHANNEL_BITS-1:0] rsp_second,
   input logic [CHANNEL_BITS-1:0] rsp_third
);

   localparam int Lat = rrc_pkg::PIPE_LATENCY;

   logic accepted;
   logic gray_req;

   assign accepted = start && !busy;
   assign gray_req = (req_first == req_second) && (req_second == req_third);

   // A reset leaves no transaction to report in the next cycle.
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result reported right after reset");

   // Every accepted transaction returns after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accepted |-> ##Lat rsp_valid)
      else $error("accepted transaction produced no result");

   // No result appears without a transaction accepted at the fixed latency before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accepted, Lat))
      else $error("result without a matching transaction");

   // A gray color has no chroma, so the result is its complementary achromatic part.
   a_gray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(accepted && gray_req, Lat) |->
         (rsp_first == ~$past(req_first, Lat)) &&
         (rsp_second == ~$past(req_first, Lat)) &&
         (rsp_third == ~$past(req_first, Lat)))
      else $error("gray color converted wrongly");

endmodule

bind rgb_ryb_color_converter rrc_checker #(
   .CHANNEL_BITS(CHANNEL_BITS)
) u_rrc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_first (req_first),
   .req_second(req_second),
   .req_third (req_third),
   .rsp_valid (rsp_valid),
   .rsp_first (rsp_first),
   .rsp_second(rsp_second),
   .rsp_third (rsp_third)
);
